>>> src/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared codes and fixed field widths of the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    // Fixed widths of the transfer fields.
    localparam int ACT_W  = 3;
    localparam int VAL_W  = 64;
    localparam int IDX_W  = 7;
    localparam int STAT_W = 2;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FASTRM = 3'd5;
    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd6;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

endpackage

>>> src/ile_mem.sv
// ----------------------------------------------------------------------------
// ile_mem
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ile_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered. Old data is returned on a same-address
    // collision.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/indexed_list_engine_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// Ordered list of words kept in a single-port-read, single-port-write RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// the o_ ports for exactly one cycle with o_done high, and cannot be held off.
// Push, insert at the end, an unused action, every rejected action and find
// or remove that needs no walk finish from idle, and the next item may follow right away.
// Pop, peek and fast remove pass through the read state for the registered RAM read.
// Insert at k shifts entries from the tail down to k, then writes the new
// word; remove at k shifts entries k+1 to the tail down. Both read one entry
// while writing its neighbor, find reads from the head to the first match
// or the tail, each one entry per cycle. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit
    import ile_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [IDX_W-1:0]  i_index,
    output logic              o_done,
    output logic [STAT_W-1:0] o_status,
    output logic [VAL_W-1:0]  o_word_out,
    output logic [IDX_W-1:0]  o_position,
    output logic              o_found,
    output logic [IDX_W-1:0]  o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_DN   = 3'd4;
    localparam logic [2:0] S_FIND = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic [AW-1:0]        r_idx, n_idx;
    logic [ACT_W-1:0]     r_act, n_act;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic                 r_done, n_done;
    logic [STAT_W-1:0]    r_status, n_status;
    logic [WORD_BITS-1:0] r_word_out, n_word_out;
    logic [IDX_W-1:0]     r_pos, n_pos;
    logic                 r_found, n_found;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic                 accept;
    logic [XW-1:0]        idx_x;
    logic [XW-1:0]        cnt_x;
    logic [XW-1:0]        ptr_x;
    logic [CW-1:0]        cnt_m1;
    logic [AW-1:0]        last_addr;
    logic [AW-1:0]        tail_addr;
    logic [AW-1:0]        in_addr;

    ile_mem #(
        .DEPTH  (CAPACITY),
        .WIDTH  (WORD_BITS),
        .ADDR_W (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Widened views for compares and the 7-bit result fields.
    assign idx_x     = XW'(i_index);
    assign cnt_x     = XW'(r_cnt);
    assign ptr_x     = XW'(r_ptr);
    assign cnt_m1    = r_cnt - 1'b1;
    assign last_addr = cnt_m1[AW-1:0];
    assign tail_addr = r_cnt[AW-1:0];
    assign in_addr   = idx_x[AW-1:0];

    // Sequencer: decode in idle, then walk the RAM one entry per cycle.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ptr      = r_ptr;
        n_idx      = r_idx;
        n_act      = r_act;
        n_word     = r_word;
        n_done     = 1'b0;
        n_status   = ST_OK;
        n_word_out = '0;
        n_pos      = '0;
        n_found    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_ptr;
        mem_wdata  = r_word;
        mem_raddr  = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act  = i_action;
                    n_word = i_value[WORD_BITS-1:0];
                    n_idx  = in_addr;
                    case (i_action)
                        ACT_PUSH: begin
                            n_done = 1'b1;
                            if (r_cnt == CAP_C) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = tail_addr;
                                mem_wdata = i_value[WORD_BITS-1:0];
                                n_cnt     = r_cnt + 1'b1;
                            end
                        end
                        ACT_POP, ACT_PEEK: begin
                            if (r_cnt == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                mem_raddr = last_addr;
                                n_state   = S_READ;
                            end
                        end
                        ACT_INSERT: begin
                            if (idx_x > cnt_x) begin
                                n_done   = 1'b1;
                                n_status = ST_RANGE;
                            end else if (r_cnt == CAP_C) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                            end else if (idx_x == cnt_x) begin
                                // Insert at the end is an append.
                                n_done    = 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = tail_addr;
                                mem_wdata = i_value[WORD_BITS-1:0];
                                n_cnt     = r_cnt + 1'b1;
                            end else begin
                                mem_raddr = last_addr;
                                n_ptr     = last_addr;
                                n_state   = S_UP;
                            end
                        end
                        ACT_REMOVE, ACT_FASTRM: begin
                            if (r_cnt == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_EMPTY;
                            end else if (idx_x >= cnt_x) begin
                                n_done   = 1'b1;
                                n_status = ST_RANGE;
                            end else if (in_addr == last_addr) begin
                                // Removing the last word only drops the count.
                                n_done = 1'b1;
                                n_cnt  = cnt_m1;
                            end else if (i_action == ACT_FASTRM) begin
                                mem_raddr = last_addr;
                                n_state   = S_READ;
                            end else begin
                                mem_raddr = in_addr + 1'b1;
                                n_ptr     = in_addr + 1'b1;
                                n_state   = S_DN;
                            end
                        end
                        ACT_FIND: begin
                            if (r_cnt == '0) begin
                                n_done = 1'b1;
                            end else begin
                                mem_raddr = '0;
                                n_ptr     = '0;
                                n_state   = S_FIND;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            // Last word is on the read data: pop, peek or fast remove.
            S_READ: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_act == ACT_FASTRM) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = mem_rdata;
                    n_cnt     = cnt_m1;
                end else begin
                    n_word_out = mem_rdata;
                    if (r_act == ACT_POP) begin
                        n_cnt = cnt_m1;
                    end
                end
            end

            // Move entry r_ptr up by one, walking toward the insert index.
            S_UP: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr + 1'b1;
                mem_wdata = mem_rdata;
                if (r_ptr == r_idx) begin
                    n_state = S_PUT;
                end else begin
                    mem_raddr = r_ptr - 1'b1;
                    n_ptr     = r_ptr - 1'b1;
                end
            end

            // Drop the new word into the opened slot.
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_word;
                n_cnt     = r_cnt + 1'b1;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end

            // Move entry r_ptr down by one, walking toward the tail.
            S_DN: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr - 1'b1;
                mem_wdata = mem_rdata;
                if (r_ptr == last_addr) begin
                    n_cnt   = cnt_m1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    mem_raddr = r_ptr + 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end
            end

            // Linear search from the head; stop at the first match.
            S_FIND: begin
                if (mem_rdata == r_word) begin
                    n_done  = 1'b1;
                    n_pos   = ptr_x[IDX_W-1:0];
                    n_found = 1'b1;
                    n_state = S_IDLE;
                end else if (r_ptr == last_addr) begin
                    n_done  = 1'b1;
                    n_pos   = cnt_x[IDX_W-1:0];
                    n_state = S_IDLE;
                end else begin
                    mem_raddr = r_ptr + 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_idx      <= n_idx;
        r_act      <= n_act;
        r_word     <= n_word;
        r_status   <= n_status;
        r_word_out <= n_word_out;
        r_pos      <= n_pos;
        r_found    <= n_found;
    end

    // Result transfer ports.
    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_word_out = VAL_W'(r_word_out);
    assign o_position = r_pos;
    assign o_found    = r_found;
    assign o_count    = cnt_x[IDX_W-1:0];

    // The list never grows past its capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_C)
        else $error("list length exceeds capacity");

    // A result only follows an accepted item or a walk in progress.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(accept) || $past(r_state != S_IDLE)))
        else $error("result strobe without a pending item");

    // An accepted push on a list with room grows it by one.
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_PUSH && r_cnt != CAP_C)
        |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("push did not grow the list");

    // A match is always reported with good status.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (o_status == ST_OK))
        else $error("find hit with bad status");

endmodule

>>> tb/list_result_checker.sv
// ----------------------------------------------------------------------------
// list_result_checker
// Predicts and checks every result of the indexed list engine.
// ----------------------------------------------------------------------------
// The checker watches command transfers on the input side and keeps its own
// copy of the list. For each accepted command it computes the expected
// result and queues it. Each strobed result is compared field by field with
// the oldest queued expectation. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------
module list_result_checker
    import ile_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [IDX_W-1:0]  i_index,
    input  logic              o_done,
    input  logic [STAT_W-1:0] o_status,
    input  logic [VAL_W-1:0]  o_word_out,
    input  logic [IDX_W-1:0]  o_position,
    input  logic              o_found,
    input  logic [IDX_W-1:0]  o_count,
    output int                o_fail_count,
    output int                o_waiting,
    output int                o_list_len,
    output int                o_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [VAL_W-1:0] WORD_MASK =
        (WORD_BITS >= VAL_W) ? {VAL_W{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  word;
        logic [IDX_W-1:0]  position;
        logic              found;
        logic [IDX_W-1:0]  count;
    } list_result_t;

    // Shadow copy of the list contents and its length.
    logic [VAL_W-1:0] list_words [CAPACITY];
    int               list_len;

    list_result_t     expected_results [$];
    int               fail_count;
    int               checked;

    // Applies one command to the shadow list and returns its expected result.
    function automatic list_result_t apply_list_op(input logic [ACT_W-1:0] act,
                                                   input logic [VAL_W-1:0] val,
                                                   input logic [IDX_W-1:0] idx);
        list_result_t     res;
        logic [VAL_W-1:0] word;
        int               n;
        int               k;
        int               i;
        res  = '0;
        word = val & WORD_MASK;
        n    = list_len;
        k    = int'(idx);
        case (act)
            ACT_PUSH: begin
                if (n >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[n] = word;
                    list_len      = n + 1;
                    res.status    = ST_OK;
                end
            end
            ACT_POP: begin
                if (n == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    list_len   = n - 1;
                    res.status = ST_OK;
                    res.word   = list_words[n-1];
                end
            end
            ACT_PEEK: begin
                if (n == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.status = ST_OK;
                    res.word   = list_words[n-1];
                end
            end
            ACT_INSERT: begin
                // The range test comes before the full test.
                if (k > n) begin
                    res.status = ST_RANGE;
                end else if (n >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = n; i > k; i--) begin
                        list_words[i] = list_words[i-1];
                    end
                    list_words[k] = word;
                    list_len      = n + 1;
                    res.status    = ST_OK;
                end
            end
            ACT_REMOVE: begin
                if (n == 0) begin
                    res.status = ST_EMPTY;
                end else if (k >= n) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = k; i + 1 < n; i++) begin
                        list_words[i] = list_words[i+1];
                    end
                    list_len   = n - 1;
                    res.status = ST_OK;
                end
            end
            ACT_FASTRM: begin
                if (n == 0) begin
                    res.status = ST_EMPTY;
                end else if (k >= n) begin
                    res.status = ST_RANGE;
                end else begin
                    list_words[k] = list_words[n-1];
                    list_len      = n - 1;
                    res.status    = ST_OK;
                end
            end
            ACT_FIND: begin
                // The position is the length when no entry matches.
                for (i = 0; i < n; i++) begin
                    if (list_words[i] == word) begin
                        break;
                    end
                end
                res.status   = ST_OK;
                res.position = IDX_W'(i);
                res.found    = (i < n);
            end
            default: begin
                res.status = ST_OK;
            end
        endcase
        res.count = IDX_W'(list_len);
        return res;
    endfunction

    // Queue the expectation of each command transfer, then check each result.
    always @(posedge i_clk) begin
        list_result_t exp_res;
        list_result_t got_res;
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
            fail_count = 0;
            checked    = 0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(apply_list_op(i_action, i_value, i_index));
            end
            if (o_done) begin
                got_res = '{o_status, o_word_out, o_position, o_found, o_count};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with no command waiting: status=%0d word=%h",
                                 $realtime, o_status, o_word_out);
                    end
                end else begin
                    exp_res = expected_results.pop_front();
                    checked++;
                    if (got_res.status !== exp_res.status ||
                        got_res.word !== exp_res.word ||
                        got_res.position !== exp_res.position ||
                        got_res.found !== exp_res.found ||
                        got_res.count !== exp_res.count) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch on result %0d", $realtime, checked);
                            $display("  expected status=%0d word=%h pos=%0d found=%0d count=%0d",
                                     exp_res.status, exp_res.word, exp_res.position,
                                     exp_res.found, exp_res.count);
                            $display("  actual   status=%0d word=%h pos=%0d found=%0d count=%0d",
                                     got_res.status, got_res.word, got_res.position,
                                     got_res.found, got_res.count);
                        end
                    end
                end
            end
        end
        o_fail_count = fail_count;
        o_waiting    = expected_results.size();
        o_list_len   = list_len;
        o_checked    = checked;
    end

endmodule

>>> tb/indexed_list_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_unit_tb
// Directed and random command stimulus for the indexed list engine.
// ----------------------------------------------------------------------------
// A short directed sequence covers every action, the empty and out-of-range
// statuses, and the boundary indexes. The list is then filled to capacity
// for the full cases, and random phases follow that favor growth, shrinkage
// or a mix, with values often from a small pool so that finds hit. Commands
// are sent in bursts with random gaps. The checker predicts and compares.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit_tb
    import ile_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 64;
    localparam int WORD_BITS    = 64;
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASE_ITEMS  = 100;

    // Phase kinds of the random part.
    localparam int PH_GROW  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIX   = 2;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
    localparam logic [VAL_W-1:0] ALL_ONES   = {VAL_W{1'b1}};

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [ACT_W-1:0]  i_action;
    logic [VAL_W-1:0]  i_value;
    logic [IDX_W-1:0]  i_index;
    logic              o_done;
    logic [STAT_W-1:0] o_status;
    logic [VAL_W-1:0]  o_word_out;
    logic [IDX_W-1:0]  o_position;
    logic              o_found;
    logic [IDX_W-1:0]  o_count;

    int fail_count;
    int waiting;
    int list_len;
    int checked;

    int               items_sent;
    int               peak_len;
    int               burst_left;
    logic [VAL_W-1:0] value_pool [8];

    indexed_list_engine_unit #(
        .CAPACITY (CAPACITY),
        .WORD_BITS(WORD_BITS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_action  (i_action),
        .i_value   (i_value),
        .i_index   (i_index),
        .o_done    (o_done),
        .o_status  (o_status),
        .o_word_out(o_word_out),
        .o_position(o_position),
        .o_found   (o_found),
        .o_count   (o_count)
    );

    list_result_checker #(
        .CAPACITY (CAPACITY),
        .WORD_BITS(WORD_BITS)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_index     (i_index),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_word_out  (o_word_out),
        .o_position  (o_position),
        .o_found     (o_found),
        .o_count     (o_count),
        .o_fail_count(fail_count),
        .o_waiting   (waiting),
        .o_list_len  (list_len),
        .o_checked   (checked)
    );

    // Free-running 10 ns clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The run is stopped if it hangs.
    initial begin
        #5_000_000;
        $display("indexed_list_engine_unit_tb: FAIL");
        $finish;
    end

    // Presents one command at a falling edge and holds it until its transfer.
    // After the transfer it either keeps start high for the next command of
    // the burst or drops it for a random gap.
    task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                            input logic [IDX_W-1:0] idx);
        int gap;
        start    = 1'b1;
        i_action = act;
        i_value  = val;
        i_index  = idx;
        do begin
            @(posedge i_clk);
        end while (busy);
        items_sent++;
        @(negedge i_clk);
        if (list_len > peak_len) begin
            peak_len = list_len;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // One burst in eight is a long stretch without gaps.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(0, 9);
            if (gap > 0) begin
                start = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Values come often from a small pool so that finds and repeats occur.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return value_pool[$urandom_range(0, 7)];
            4:          return '0;
            5:          return ALL_ONES;
            6:          return VAL_W'($urandom_range(0, 3));
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    // Indexes are mostly valid for the action, sometimes at the boundary,
    // and sometimes anywhere in the seven-bit range.
    function automatic logic [IDX_W-1:0] pick_index(input logic [ACT_W-1:0] act,
                                                    input int len);
        int top;
        int sel;
        top = (act == ACT_INSERT) ? len : ((len > 0) ? len - 1 : 0);
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
            return IDX_W'($urandom_range(0, top));
        end else if (sel == 8) begin
            return IDX_W'(len + $urandom_range(0, 1));
        end
        return IDX_W'($urandom_range(0, 127));
    endfunction

    // Chooses an action with weights that follow the phase kind.
    function automatic logic [ACT_W-1:0] pick_action(input int phase_kind);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase_kind)
            PH_GROW: begin
                if (roll < 40) return ACT_PUSH;
                if (roll < 70) return ACT_INSERT;
                if (roll < 75) return ACT_POP;
                if (roll < 80) return ACT_PEEK;
                if (roll < 85) return ACT_REMOVE;
                if (roll < 90) return ACT_FASTRM;
                return ACT_FIND;
            end
            PH_DRAIN: begin
                if (roll < 10) return ACT_PUSH;
                if (roll < 15) return ACT_INSERT;
                if (roll < 40) return ACT_POP;
                if (roll < 45) return ACT_PEEK;
                if (roll < 65) return ACT_REMOVE;
                if (roll < 85) return ACT_FASTRM;
                return ACT_FIND;
            end
            default: begin
                if (roll < 4) return ACT_UNUSED;
                return ACT_W'($urandom_range(0, 6));
            end
        endcase
    endfunction

    // Stimulus and verdict.
    initial begin
        logic [ACT_W-1:0] act;
        int               phase_kind;
        int               phase_plan [8];
        start      = 1'b0;
        i_action   = ACT_PUSH;
        i_value    = '0;
        i_index    = '0;
        i_rst_n    = 1'b0;
        items_sent = 0;
        peak_len   = 0;
        burst_left = 0;
        phase_plan = '{PH_GROW, PH_MIX, PH_DRAIN, PH_GROW, PH_GROW, PH_MIX, PH_DRAIN, PH_MIX};
        foreach (value_pool[i]) begin
            value_pool[i] = {$urandom, $urandom};
        end
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Empty list: every action that removes or returns a word is rejected, and find misses.
        send_cmd(ACT_POP, '0, '0);
        send_cmd(ACT_PEEK, '0, '0);
        send_cmd(ACT_REMOVE, '0, '0);
        send_cmd(ACT_FASTRM, '0, '0);
        send_cmd(ACT_FIND, '0, '0);
        send_cmd(ACT_INSERT, ALL_ONES, 7'd1);
        send_cmd(ACT_REMOVE, '0, 7'd127);
        // Insert at the length appends; then a few words around the extremes.
        send_cmd(ACT_INSERT, ALL_ONES, 7'd0);
        send_cmd(ACT_PUSH, '0, '0);
        send_cmd(ACT_PUSH, 64'h8000_0000_0000_0001, '0);
        send_cmd(ACT_PEEK, '0, '0);
        send_cmd(ACT_INSERT, 64'h5555_5555_5555_5555, 7'd1);
        send_cmd(ACT_FIND, ALL_ONES, '0);
        send_cmd(ACT_FIND, '0, '0);
        send_cmd(ACT_FIND, 64'h0000_0000_0000_1234, '0);
        send_cmd(ACT_REMOVE, '0, 7'd4);
        send_cmd(ACT_REMOVE, '0, 7'd0);
        send_cmd(ACT_FASTRM, '0, 7'd0);
        send_cmd(ACT_FASTRM, '0, 7'd2);
        send_cmd(ACT_UNUSED, ALL_ONES, 7'd127);
        send_cmd(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 7'd127);
        send_cmd(ACT_POP, '0, '0);
        send_cmd(ACT_POP, '0, '0);

        // Fill to capacity, then the full-list cases and the longest walks.
        while (list_len < CAPACITY) begin
            send_cmd(ACT_PUSH, pick_value(), '0);
        end
        send_cmd(ACT_PUSH, ALL_ONES, '0);
        send_cmd(ACT_INSERT, ALL_ONES, 7'd10);
        send_cmd(ACT_INSERT, ALL_ONES, IDX_W'(CAPACITY + 1));
        send_cmd(ACT_FIND, 64'hDEAD_0000_BEEF_0000, '0);
        send_cmd(ACT_REMOVE, '0, 7'd0);
        send_cmd(ACT_INSERT, pick_value(), 7'd0);

        // Random phases with growth, shrinkage or a mix.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase_kind = phase_plan[(n / PHASE_ITEMS) % 8];
            act = pick_action(phase_kind);
            send_cmd(act, pick_value(), pick_index(act, list_len));
        end
        start = 1'b0;

        // Drain the outstanding results, then watch for stray ones.
        while (waiting != 0) begin
            @(negedge i_clk);
        end
        repeat (CAPACITY + 8) @(negedge i_clk);

        $display("Sent %0d commands over all seven actions and the unused code;",
                 items_sent);
        $display("%0d results checked.", checked);
        $display("List length peaked at %0d of %0d entries, with empty, full and range rejects.",
                 peak_len, CAPACITY);
        if (fail_count == 0 && waiting == 0) begin
            $display("indexed_list_engine_unit_tb: PASS");
        end else begin
            $display("indexed_list_engine_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
